>>> hdl/aes128_ctr_nocarry_keystream_unit_assert.svh
// assertion macros for the aes ctr keystream unit
// used by the checker module only
`ifndef AES128_CTR_NOCARRY_KEYSTREAM_UNIT_ASSERT_SVH
`define AES128_CTR_NOCARRY_KEYSTREAM_UNIT_ASSERT_SVH
// property that must hold on every clock edge out of reset
`define ACK_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property that must hold on every clock edge, reset included
`define ACK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> hdl/ack_pkg.sv
// package for the aes ctr keystream unit: types, constants, aes byte functions
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ack_pkg;

  localparam int unsigned MaxRunDefault = 64;
  localparam int unsigned NumRounds = 10;
  localparam int unsigned AddrW = 4;

  localparam logic [AddrW-1:0] RegKeyLo = 4'h0;
  localparam logic [AddrW-1:0] RegKeyHi = 4'h8;

  typedef logic [127:0] blk_t;

  // aes byte order: byte k of the string sits at bits 8k+7:8k
  function automatic logic [7:0] gf_dbl(input logic [7:0] a);
    gf_dbl = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = t[a];
  endfunction

  // one round: sub bytes, shift rows, optional mix columns, add round key
  function automatic blk_t aes_round(input blk_t s, input blk_t rk, input logic last);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    blk_t o;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        t[4*c+j] = sbox(s[8*(4*((c+j)%4)+j) +: 8]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      if (last) begin
        o[32*c +: 32] = {a3, a2, a1, a0};
      end else begin
        o[32*c +: 8]    = gf_dbl(a0) ^ gf_dbl(a1) ^ a1 ^ a2 ^ a3;
        o[32*c+8 +: 8]  = a0 ^ gf_dbl(a1) ^ gf_dbl(a2) ^ a2 ^ a3;
        o[32*c+16 +: 8] = a0 ^ a1 ^ gf_dbl(a2) ^ gf_dbl(a3) ^ a3;
        o[32*c+24 +: 8] = gf_dbl(a0) ^ a0 ^ a1 ^ a2 ^ gf_dbl(a3);
      end
    end
    aes_round = o ^ rk;
  endfunction

  // next round key from the previous one
  function automatic blk_t key_step(input blk_t w, input logic [7:0] rcon);
    logic [31:0] t;
    blk_t o;
    t = {sbox(w[103:96]), sbox(w[127:120]), sbox(w[119:112]), sbox(w[111:104]) ^ rcon};
    for (int c = 0; c < 4; c++) begin
      t = t ^ w[32*c +: 32];
      o[32*c +: 32] = t;
    end
    key_step = o;
  endfunction

endpackage
`default_nettype wire

>>> hdl/ack_rounds.sv
// ten-stage aes-128 round pipeline, one round per stage, stall holds all stages
// depends on ack_pkg
`timescale 1ns / 1ps
`default_nettype none
module ack_rounds import ack_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         adv_i,
  input  wire logic         valid_i,
  input  wire blk_t         state_i,
  input  wire logic         last_i,
  input  wire blk_t         rk_i [NumRounds+1],
  output logic              valid_o,
  output blk_t              state_o,
  output logic              last_o
);
  logic v_q [NumRounds];
  logic l_q [NumRounds];
  blk_t s_q [NumRounds];

  // stage 0 takes round 1 on the whitened input, each later stage one more round
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NumRounds; r++) v_q[r] <= 1'b0;
    end else if (adv_i) begin
      v_q[0] <= valid_i;
      for (int r = 1; r < NumRounds; r++) v_q[r] <= v_q[r-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s_q[0] <= aes_round(state_i ^ rk_i[0], rk_i[1], 1'b0);
      l_q[0] <= last_i;
      for (int r = 1; r < NumRounds; r++) begin
        s_q[r] <= aes_round(s_q[r-1], rk_i[r+1], (r == NumRounds-1));
        l_q[r] <= l_q[r-1];
      end
    end
  end

  assign valid_o = v_q[NumRounds-1];
  assign state_o = s_q[NumRounds-1];
  assign last_o  = l_q[NumRounds-1];
endmodule
`default_nettype wire

>>> hdl/aes128_ctr_nocarry_keystream_unit.sv
// AES-128 counter-mode keystream unit with no carry out of the low counter half.
// One request of N blocks (saturated to MAX_RUN) enters the ten-stage round
// pipeline one block per cycle while the output is not stalled. The request item
// is accepted first and its N blocks then issue one after another (none for a
// zero count); no new item is taken until the last block has issued. Each block
// passes the round stages and then the output register, and a stalled output
// holds the whole pipeline. Requests queue behind each other, the issue counter
// being the unit that sets the rate. Key writes re-expand the round keys
// one round per cycle, and the input stalls while that runs, right after reset
// too; write keys only while idle. Depends on ack_pkg and ack_rounds.
`timescale 1ns / 1ps
`default_nettype none
module aes128_ctr_nocarry_keystream_unit import ack_pkg::*; #(
  parameter int unsigned MAX_RUN = MaxRunDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [AddrW-1:0]  paddr,
  input  wire logic [63:0]       pwdata,
  output logic [63:0]            prdata,
  output logic                   pready,
  input  wire logic              valid_i,
  output logic                   stall_o,
  input  wire logic [63:0]       counter_low_i,
  input  wire logic [63:0]       counter_high_i,
  input  wire logic [6:0]        block_count_i,
  output logic                   valid_o,
  input  wire logic              stall_i,
  output logic [63:0]            cipher_low_o,
  output logic [63:0]            cipher_high_o,
  output logic                   last_block_o
);
  localparam logic [6:0] MaxRunC = 7'(MAX_RUN);

  // key registers and round key expansion
  logic [63:0] key_lo_q, key_hi_q;
  blk_t        rk_q [NumRounds+1];
  logic [3:0]  kx_q;
  logic [7:0]  rcon_q;
  logic        wr;
  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr)
      RegKeyLo: prdata = key_lo_q;
      RegKeyHi: prdata = key_hi_q;
      default:  prdata = '0;
    endcase
  end

  // after reset the expansion runs too, from the all-zero key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q <= '0;
      key_hi_q <= '0;
      kx_q     <= 4'd1;
      rcon_q   <= 8'h01;
      for (int r = 0; r <= NumRounds; r++) rk_q[r] <= '0;
    end else if (wr && (paddr == RegKeyLo || paddr == RegKeyHi)) begin
      if (paddr == RegKeyLo) begin
        key_lo_q <= pwdata;
        rk_q[0]  <= {key_hi_q, pwdata};
      end else begin
        key_hi_q <= pwdata;
        rk_q[0]  <= {pwdata, key_lo_q};
      end
      kx_q   <= 4'd1;
      rcon_q <= 8'h01;
    end else if (kx_q != 4'd0) begin
      rk_q[kx_q] <= key_step(rk_q[kx_q - 4'd1], rcon_q);
      rcon_q     <= gf_dbl(rcon_q);
      kx_q       <= (kx_q == 4'(NumRounds)) ? 4'd0 : kx_q + 4'd1;
    end
  end

  // request issue: one counter block per cycle while the pipeline advances
  logic        busy_q;
  logic [63:0] clo_q, chi_q;
  logic [6:0]  idx_q, cnt_q;
  logic        adv, iss_last;
  logic [6:0]  n_sat;
  assign n_sat    = (block_count_i > MaxRunC) ? MaxRunC : block_count_i;
  assign iss_last = (idx_q + 7'd1 == cnt_q);
  assign stall_o  = busy_q || (kx_q != 4'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      cnt_q  <= '0;
    end else if (!stall_o) begin
      if (valid_i && n_sat != 7'd0) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
        cnt_q  <= n_sat;
      end
    end else if (busy_q && adv) begin
      idx_q <= idx_q + 7'd1;
      if (iss_last) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      clo_q <= counter_low_i;
      chi_q <= counter_high_i;
    end
  end

  // output register; pipeline moves when output slot frees
  logic v_out_q, p_valid, p_last;
  blk_t p_state, out_q;
  logic l_out_q;
  assign adv = !v_out_q || !stall_i;

  ack_rounds u_rounds (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(busy_q),
    .state_i({chi_q, clo_q + {57'd0, idx_q}}), .last_i(iss_last), .rk_i(rk_q),
    .valid_o(p_valid), .state_o(p_state), .last_o(p_last)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_out_q <= 1'b0;
    else if (adv) v_out_q <= p_valid;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q   <= p_state;
      l_out_q <= p_last;
    end
  end

  assign valid_o       = v_out_q;
  assign cipher_low_o  = out_q[63:0];
  assign cipher_high_o = out_q[127:64];
  assign last_block_o  = l_out_q;
endmodule
`default_nettype wire

>>> hdl/ack_checker.sv
// port-level checker for the aes ctr keystream unit, bound to the top level
// depends on the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "aes128_ctr_nocarry_keystream_unit_assert.svh"
module ack_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        valid_o,
  input wire logic        stall_i,
  input wire logic [63:0] cipher_low_o,
  input wire logic        last_block_o,
  input wire logic        pready
);
  // held result item stays put
  `ACK_ASSERT(a_hold, clk_i, rst_ni, valid_o && stall_i |=> valid_o && $stable(cipher_low_o), "held item changed")
  `ACK_ASSERT(a_last, clk_i, rst_ni, valid_o && stall_i |=> $stable(last_block_o), "held last flag changed")
  // config port never waits
  `ACK_ASSERT_ALWAYS(a_rdy, clk_i, pready, "pready low")
  // no result item during reset
  `ACK_ASSERT_ALWAYS(a_rst, clk_i, !rst_ni |-> !valid_o, "valid during reset")
endmodule
bind aes128_ctr_nocarry_keystream_unit ack_checker u_ack_checker (.*);
`default_nettype wire
